/* rtl/rlf_pkg.sv */
package rlf_pkg;

    // Sizes of the fixed fields.
    localparam int PHASE_W      = 16;
    localparam int LED_IDX_W    = 6;
    localparam int HUE_DEG_W    = 9;
    localparam int BYTE_W       = 8;
    localparam int MODE_W       = 2;
    localparam int APB_ADDR_W   = 4;
    localparam int APB_DATA_W   = 32;

    localparam int NUM_LEDS_DEFAULT = 64;
    localparam int OUT_FIFO_DEPTH   = 4;

    // Register map, indexed by paddr[3:2].
    localparam logic [1:0] REG_EFFECT_MODE = 2'd0;
    localparam logic [1:0] REG_BASE_HUE    = 2'd1;
    localparam logic [1:0] REG_BRIGHTNESS  = 2'd2;

    // Effect modes. The unused code behaves as MODE_BASE.
    localparam logic [MODE_W-1:0] MODE_BASE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RANDOM = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RAIN   = 2'd2;

    localparam logic [BYTE_W-1:0] RNG_RESET      = 8'hA3;
    localparam logic [BYTE_W-1:0] RNG_ZERO_SUB   = 8'h5B;
    localparam logic [BYTE_W-1:0] LEVEL_FULL     = 8'hFF;
    localparam logic [BYTE_W-1:0] FADE_DROP      = 8'd6;
    localparam logic [BYTE_W-1:0] FADE_RAIN      = 8'd10;
    localparam logic [BYTE_W-1:0] BRIGHT_RESET   = 8'd255;

    // hue * 360 / 255 = (hue * 24) / 17, the division done as a multiply by
    // ceil(2^20 / 17); exact for every product below 2^20.
    localparam int               HUE_DEG_SHIFT = 20;
    localparam logic [20:0]      HUE_DEG_MUL   = 21'd1480344;

    // base_hue * 255 / 360 = (base_hue * 17) / 24, the division done as a
    // multiply by ceil(2^19 / 24); exact for every product below 2^15.
    localparam int               BASE_BYTE_SHIFT = 19;
    localparam logic [14:0]      BASE_BYTE_MUL   = 15'd21846;

    typedef struct packed {
        logic [LED_IDX_W-1:0] led_index;
        logic [HUE_DEG_W-1:0] hue_degrees;
        logic [BYTE_W-1:0]    value_level;
        logic                 last_led;
    } rlf_result_t;

    // One step of the 8-bit xorshift generator (shifts 1, 1, 2).
    function automatic logic [BYTE_W-1:0] rng_step(input logic [BYTE_W-1:0] x);
        logic [BYTE_W-1:0] a;
        logic [BYTE_W-1:0] b;
        logic [BYTE_W-1:0] c;
        a = x ^ {x[6:0], 1'b0};
        b = a ^ {1'b0, a[7:1]};
        c = b ^ {b[5:0], 2'b00};
        return (c != 8'h00) ? c : RNG_ZERO_SUB;
    endfunction

endpackage

/* rtl/rlf_ram.sv */
module rlf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/rlf_out_fifo.sv */
module rlf_out_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    input  rlf_pkg::rlf_result_t           push_data,
    output logic                           pop_valid,
    input  logic                           pop_ready,
    output rlf_pkg::rlf_result_t           pop_data,
    output logic [$clog2(DEPTH+1)-1:0]     count
);
    import rlf_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rlf_result_t       mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              pop;

    assign pop = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_valid = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];
    assign count     = count_reg;

`ifndef NO_ASSERTIONS
    // The upstream credit check must never let a word arrive into a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && !pop && (count_reg == CNT_W'(DEPTH))))
        else $error("output queue overflow");
`endif

endmodule

/* rtl/raindrop_led_fader.sv */
// Channel   | Handshake              | Payload                                   | Word
// --------- | ---------------------- | ----------------------------------------- | -------------
// input     | in_valid / in_ready    | phase                                     | one frame
// output    | out_valid / out_ready  | led_index, hue_degrees, value_level,      | one LED result
//           |                        | last_led                                  |
// config    | APB psel/penable/...   | paddr, pwdata, prdata                     | one register
//
// A frame fills the LED memory if it is the very first frame after reset, seeds
// a drop when the phase asks for one, then walks the LED memory, one entry read
// and written back per cycle while the output credit allows it. Reset (rst_n,
// asynchronous) clears the control state and the generator; the LED memory
// holds nothing until the first frame fills it. A stall on the output holds the
// walk through a credit check against a four-word output queue, so no word is
// dropped.
module raindrop_led_fader #(
    parameter int NUM_LEDS = rlf_pkg::NUM_LEDS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [rlf_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [rlf_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [rlf_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready,

    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [rlf_pkg::PHASE_W-1:0]        phase,

    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [rlf_pkg::LED_IDX_W-1:0]      led_index,
    output logic [rlf_pkg::HUE_DEG_W-1:0]      hue_degrees,
    output logic [rlf_pkg::BYTE_W-1:0]         value_level,
    output logic                               last_led
);
    import rlf_pkg::*;

    localparam int IDX_W   = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
    localparam int CNT_W   = $clog2(NUM_LEDS + 1);
    localparam int FCNT_W  = $clog2(OUT_FIFO_DEPTH + 1);
    localparam int RECIP_W = 17;
    // floor(2^16 / NUM_LEDS): the quotient estimate of an 8-bit draw is low by
    // at most one, which a single compare and subtract corrects.
    localparam logic [RECIP_W-1:0] KEY_RECIP = RECIP_W'((1 << 16) / NUM_LEDS);
    localparam logic [8:0]         KEY_MOD   = 9'(NUM_LEDS);
    localparam logic [IDX_W-1:0]   LAST_IDX  = IDX_W'(NUM_LEDS - 1);
    localparam logic [CNT_W-1:0]   LED_COUNT = CNT_W'(NUM_LEDS);
    localparam logic [CNT_W-1:0]   LED_LAST  = CNT_W'(NUM_LEDS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_DRAW,
        S_QUOT,
        S_KEY,
        S_WALK
    } state_t;

    // Configuration registers.
    logic [MODE_W-1:0]     effect_mode_reg;
    logic [HUE_DEG_W-1:0]  base_hue_reg;
    logic [BYTE_W-1:0]     brightness_reg;
    logic                  cfg_write;
    logic [1:0]            cfg_idx;

    // Control state.
    state_t                state_reg;
    logic                  stores_ready_reg;
    logic [BYTE_W-1:0]     rng_reg;
    logic                  seed_reg;
    logic [CNT_W-1:0]      issue_cnt_reg;
    logic                  p0_valid_reg;
    logic                  s1_valid_reg;

    // Datapath registers.
    logic [BYTE_W-1:0]     draw_reg;
    logic [BYTE_W-1:0]     quot_reg;
    logic [BYTE_W-1:0]     hue_seed_reg;
    logic [IDX_W-1:0]      p0_idx_reg;
    logic [IDX_W-1:0]      s1_idx_reg;
    logic                  s1_last_reg;
    logic [HUE_DEG_W-1:0]  s1_hue_deg_reg;
    logic [15:0]           s1_prod_reg;

    // Combinational values.
    logic                  rain;
    logic                  random_hue;
    logic                  seed_next;
    logic [BYTE_W-1:0]     fade;
    logic [BYTE_W-1:0]     rng_next;
    logic [24:0]           key_prod;
    logic [BYTE_W-1:0]     quot_next;
    logic [13:0]           base_x17;
    logic [28:0]           base_prod;
    logic [9:0]            base_quot;
    logic [BYTE_W-1:0]     base_byte;
    logic [BYTE_W-1:0]     hue_seed_next;
    logic [8:0]            key_sub;
    logic [8:0]            key_rem;
    logic [IDX_W-1:0]      key_idx;
    logic                  issue;
    logic [FCNT_W:0]       credit_used;
    logic [FCNT_W-1:0]     fifo_count;

    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [15:0]           ram_wdata;
    logic [15:0]           ram_rdata;
    logic [BYTE_W-1:0]     rd_hue;
    logic [BYTE_W-1:0]     rd_level;
    logic [BYTE_W-1:0]     level_faded;
    logic [28:0]           hue_prod;
    logic [16:0]           value_sum;
    rlf_result_t           push_data;
    rlf_result_t           pop_data;

    // ------------------------------------------------------------------
    // Configuration port. Writes complete in the access phase; pready is
    // tied high, so there are never wait states.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            effect_mode_reg <= MODE_BASE;
            base_hue_reg    <= '0;
            brightness_reg  <= BRIGHT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                REG_EFFECT_MODE: effect_mode_reg <= pwdata[MODE_W-1:0];
                REG_BASE_HUE:    base_hue_reg    <= pwdata[HUE_DEG_W-1:0];
                REG_BRIGHTNESS:  brightness_reg  <= pwdata[BYTE_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_EFFECT_MODE: prdata = APB_DATA_W'(effect_mode_reg);
            REG_BASE_HUE:    prdata = APB_DATA_W'(base_hue_reg);
            REG_BRIGHTNESS:  prdata = APB_DATA_W'(brightness_reg);
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Mode decode. Pixel rain seeds on every even phase and fades faster;
    // the raindrop modes seed on every fourth phase.
    // ------------------------------------------------------------------
    assign rain       = (effect_mode_reg == MODE_RAIN);
    assign random_hue = (effect_mode_reg == MODE_RANDOM) || rain;
    assign seed_next  = rain ? !phase[0] : (phase[1:0] == 2'b00);
    assign fade       = rain ? FADE_RAIN : FADE_DROP;
    assign rng_next   = rng_step(rng_reg);

    // Seed key: draw mod NUM_LEDS by reciprocal multiply, then one fix-up.
    assign key_prod  = 25'(draw_reg) * 25'(KEY_RECIP);
    assign quot_next = key_prod[23:16];
    assign key_sub   = 9'({1'b0, draw_reg}) - 9'(quot_reg * KEY_MOD);
    assign key_rem   = (key_sub >= KEY_MOD) ? (key_sub - KEY_MOD) : key_sub;
    assign key_idx   = key_rem[IDX_W-1:0];

    // Base hue in degrees to a hue byte, saturating for out-of-range input.
    assign base_x17  = 14'({base_hue_reg, 4'b0000}) + 14'(base_hue_reg);
    assign base_prod = 29'(base_x17) * 29'(BASE_BYTE_MUL);
    assign base_quot = base_prod[BASE_BYTE_SHIFT +: 10];
    assign base_byte = (base_quot > 10'd255) ? LEVEL_FULL : base_quot[BYTE_W-1:0];
    assign hue_seed_next = random_hue ? rng_next : base_byte;

    // ------------------------------------------------------------------
    // Frame sequencer. A frame optionally fills the memory, optionally
    // seeds one drop, then walks every LED once.
    // ------------------------------------------------------------------
    assign in_ready    = (state_reg == S_IDLE);
    assign credit_used = (FCNT_W + 1)'(fifo_count) + (FCNT_W + 1)'(p0_valid_reg)
                       + (FCNT_W + 1)'(s1_valid_reg);
    assign issue       = (state_reg == S_WALK) && (issue_cnt_reg < LED_COUNT)
                       && (credit_used < (FCNT_W + 1)'(OUT_FIFO_DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            stores_ready_reg <= 1'b0;
            rng_reg          <= RNG_RESET;
            seed_reg         <= 1'b0;
            issue_cnt_reg    <= '0;
            p0_valid_reg     <= 1'b0;
            s1_valid_reg     <= 1'b0;
        end
        else
        begin
            p0_valid_reg <= issue;
            s1_valid_reg <= p0_valid_reg;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        seed_reg      <= seed_next;
                        issue_cnt_reg <= '0;
                        if (!stores_ready_reg)
                        begin
                            state_reg <= S_INIT;
                        end
                        else if (seed_next)
                        begin
                            state_reg <= S_DRAW;
                        end
                        else
                        begin
                            state_reg <= S_WALK;
                        end
                    end
                end
                S_INIT:
                begin
                    rng_reg       <= rng_next;
                    issue_cnt_reg <= issue_cnt_reg + 1'b1;
                    if (issue_cnt_reg == LED_LAST)
                    begin
                        stores_ready_reg <= 1'b1;
                        issue_cnt_reg    <= '0;
                        state_reg        <= seed_reg ? S_DRAW : S_WALK;
                    end
                end
                S_DRAW:
                begin
                    rng_reg   <= rng_next;
                    state_reg <= S_QUOT;
                end
                S_QUOT:
                begin
                    if (random_hue)
                    begin
                        rng_reg <= rng_next;
                    end
                    state_reg <= S_KEY;
                end
                S_KEY:
                begin
                    state_reg <= S_WALK;
                end
                S_WALK:
                begin
                    if (issue)
                    begin
                        issue_cnt_reg <= issue_cnt_reg + 1'b1;
                    end
                    if ((issue_cnt_reg == LED_COUNT) && !p0_valid_reg && !s1_valid_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Walk pipeline: read at issue, fade and write back when the data
    // returns, then scale and queue the result word.
    // ------------------------------------------------------------------
    assign rd_hue      = ram_rdata[15:8];
    assign rd_level    = ram_rdata[7:0];
    assign level_faded = (rd_level > fade) ? (rd_level - fade) : '0;
    assign hue_prod    = 29'(rd_hue) * 29'(HUE_DEG_MUL);

    always_ff @(posedge clk)
    begin
        if (state_reg == S_DRAW)
        begin
            draw_reg <= rng_next;
        end
        if (state_reg == S_QUOT)
        begin
            quot_reg     <= quot_next;
            hue_seed_reg <= hue_seed_next;
        end
        p0_idx_reg     <= issue_cnt_reg[IDX_W-1:0];
        s1_idx_reg     <= p0_idx_reg;
        s1_last_reg    <= (p0_idx_reg == LAST_IDX);
        s1_hue_deg_reg <= hue_prod[HUE_DEG_SHIFT +: HUE_DEG_W];
        s1_prod_reg    <= 16'(brightness_reg) * 16'(level_faded);
    end

    // Memory write: fill, seed and write-back never share a cycle.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = p0_idx_reg;
        ram_wdata = {rd_hue, level_faded};
        if (state_reg == S_INIT)
        begin
            ram_we    = 1'b1;
            ram_waddr = issue_cnt_reg[IDX_W-1:0];
            ram_wdata = {rng_next, 8'h00};
        end
        else if (state_reg == S_KEY)
        begin
            ram_we    = 1'b1;
            ram_waddr = key_idx;
            ram_wdata = {hue_seed_reg, LEVEL_FULL};
        end
        else if (p0_valid_reg)
        begin
            ram_we = 1'b1;
        end
    end

    rlf_ram #(
        .WIDTH (2 * BYTE_W),
        .DEPTH (NUM_LEDS)
    ) u_led_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (issue_cnt_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    // x / 255 for x up to 255 * 255 is (x + (x >> 8) + 1) >> 8.
    assign value_sum = 17'(s1_prod_reg) + 17'(s1_prod_reg[15:8]) + 17'd1;

    assign push_data.led_index   = LED_IDX_W'(s1_idx_reg);
    assign push_data.hue_degrees = s1_hue_deg_reg;
    assign push_data.value_level = value_sum[15:8];
    assign push_data.last_led    = s1_last_reg;

    rlf_out_fifo #(
        .DEPTH (OUT_FIFO_DEPTH)
    ) u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s1_valid_reg),
        .push_data (push_data),
        .pop_valid (out_valid),
        .pop_ready (out_ready),
        .pop_data  (pop_data),
        .count     (fifo_count)
    );

    assign led_index   = pop_data.led_index;
    assign hue_degrees = pop_data.hue_degrees;
    assign value_level = pop_data.value_level;
    assign last_led    = pop_data.last_led;

`ifndef NO_ASSERTIONS
    // The first frame after reset always fills the memory before anything else.
    a_first_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !stores_ready_reg) |=> (state_reg == S_INIT))
        else $error("first frame skipped the memory fill");

    // Words in flight plus queued words never exceed the queue depth.
    a_credit: assert property (@(posedge clk) disable iff (!rst_n)
        credit_used <= (FCNT_W + 1)'(OUT_FIFO_DEPTH))
        else $error("walk issued beyond the output credit");

    // The walk counter never runs past the LED count.
    a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        issue_cnt_reg <= LED_COUNT)
        else $error("walk counter past the LED count");
`endif

endmodule
